>>> rtl/pci_config_space_pam_decode_defines.svh
// Assertion macros shared by the checker of the PAM decode block.
// Depends on nothing; included by the checker file.
`ifndef PCI_CONFIG_SPACE_PAM_DECODE_DEFINES_SVH
`define PCI_CONFIG_SPACE_PAM_DECODE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcpd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcpd assertion failed");

`endif

>>> rtl/pcpd_pkg.sv
// Types, codes and constant tables of the PCI host bridge configuration space.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pcpd_pkg;

  localparam logic       OP_READ   = 1'b0;
  localparam logic       OP_WRITE  = 1'b1;
  localparam logic       KIND_READ = 1'b0;
  localparam logic       KIND_MAP  = 1'b1;
  localparam logic [2:0] FUNC0     = 3'd0;

  localparam logic [7:0] ADDR_PAM0 = 8'h59;
  localparam logic [7:0] ADDR_PAM5 = 8'h5E;
  localparam logic [7:0] ADDR_PAM6 = 8'h5F;

  localparam logic [19:0] BASE_F0000 = 20'hF0000;
  localparam logic [19:0] BASE_E0000 = 20'hE0000;
  localparam logic [19:0] BASE_E4000 = 20'hE4000;
  localparam logic [19:0] BASE_E8000 = 20'hE8000;
  localparam logic [19:0] BASE_EC000 = 20'hEC000;
  localparam logic [16:0] SIZE_16K   = 17'h04000;
  localparam logic [16:0] SIZE_64K   = 17'h10000;
  localparam logic [7:0]  RDATA_NONE = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SECOND
  } state_t;

  typedef struct packed {
    logic       op;
    logic [2:0] func_num;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rdata;
    logic [19:0] region_base;
    logic [16:0] region_size;
    logic        reads_to_dram;
    logic        writes_to_dram;
    logic        shadow_bios;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    logic       wr_en;
    logic       shadow_nxt;
    res_t       r0;
    res_t       r1;
  } dec_t;

  function automatic logic [7:0] cfg_reset_byte(input logic [7:0] addr);
    logic [7:0] b;
    b = 8'h00;
    case (addr) inside
      8'h00:           b = 8'h86;
      8'h01:           b = 8'h80;
      8'h02:           b = 8'h30;
      8'h03:           b = 8'h70;
      8'h04:           b = 8'h06;
      8'h07:           b = 8'h02;
      8'h0B:           b = 8'h06;
      8'h52:           b = 8'h42;
      8'h53:           b = 8'h14;
      8'h56:           b = 8'h52;
      8'h57:           b = 8'h01;
      [8'h60:8'h64]:   b = 8'h02;
      8'h67:           b = 8'h11;
      8'h69:           b = 8'h03;
      8'h70:           b = 8'h20;
      8'h72:           b = 8'h02;
      8'h74:           b = 8'h0E;
      8'h78:           b = 8'h23;
      default:         b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic res_t map_res(input logic [19:0] base, input logic [16:0] size,
                                   input logic [3:0] nib, input logic shadow);
    res_t r;
    r                = '0;
    r.kind           = KIND_MAP;
    r.region_base    = base;
    r.region_size    = size;
    r.reads_to_dram  = nib[0];
    r.writes_to_dram = nib[1];
    r.shadow_bios    = shadow;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pcpd_mem.sv
// Configuration byte store: 256 x 8 synchronous memory with registered read.
// Valid bits make unwritten bytes read as their reset value. Uses pcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcpd_mem
  import pcpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       rd_en,
  input  wire logic [7:0] rd_addr,
  output logic      [7:0] rd_data,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_addr,
  input  wire logic [7:0] wr_data
);

  logic [7:0]   mem_r [256];
  logic [255:0] vld_r;
  logic [7:0]   rd_q_r;
  logic [7:0]   rd_addr_r;
  logic         rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= mem_r[rd_addr];
      rd_addr_r <= rd_addr;
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : cfg_reset_byte(rd_addr_r);

endmodule

`default_nettype wire

>>> rtl/pcpd_decode.sv
// Access decode: builds read results, write enables and PAM region updates
// from a request and the old stored byte. Uses pcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcpd_decode
  import pcpd_pkg::*;
(
  input  wire req_t       req,
  input  wire logic [7:0] old_byte,
  input  wire logic       shadow,
  output dec_t            dec
);

  logic [7:0]  chg;
  logic        lo_chg;
  logic        hi_chg;
  logic        prot;
  logic        is_pam56;
  logic [19:0] lo_base;
  logic [19:0] hi_base;

  assign chg      = old_byte ^ req.wdata;
  assign lo_chg   = |chg[3:0];
  assign hi_chg   = |chg[7:4];
  assign prot     = req.reg_addr inside {[8'h00:8'h03], [8'h08:8'h0B], 8'h0E};
  assign is_pam56 = (req.reg_addr == ADDR_PAM5) || (req.reg_addr == ADDR_PAM6);
  assign lo_base  = (req.reg_addr == ADDR_PAM5) ? BASE_E0000 : BASE_E8000;
  assign hi_base  = (req.reg_addr == ADDR_PAM5) ? BASE_E4000 : BASE_EC000;

  always_comb begin
    dec            = '0;
    dec.shadow_nxt = shadow;
    if (req.op == OP_READ) begin
      dec.n              = 2'd1;
      dec.r0.kind        = KIND_READ;
      dec.r0.rdata       = (req.func_num != FUNC0) ? RDATA_NONE : old_byte;
      dec.r0.shadow_bios = shadow;
    end else if ((req.func_num == FUNC0) && !prot) begin
      dec.wr_en = 1'b1;
      if (req.reg_addr == ADDR_PAM0) begin
        if (hi_chg) begin
          dec.n          = 2'd1;
          dec.shadow_nxt = req.wdata[4];
          dec.r0         = map_res(BASE_F0000, SIZE_64K, req.wdata[7:4], req.wdata[4]);
        end
      end else if (is_pam56) begin
        if (lo_chg) begin
          dec.n  = hi_chg ? 2'd2 : 2'd1;
          dec.r0 = map_res(lo_base, SIZE_16K, req.wdata[3:0], shadow);
          dec.r1 = map_res(hi_base, SIZE_16K, req.wdata[7:4], shadow);
        end else if (hi_chg) begin
          dec.n  = 2'd1;
          dec.r0 = map_res(hi_base, SIZE_16K, req.wdata[7:4], shadow);
        end
      end
    end
    dec.r0.last = (dec.n == 2'd1);
    dec.r1.last = 1'b1;
  end

endmodule

`default_nettype wire

>>> rtl/pci_config_space_pam_decode.sv
// PCI host bridge configuration space with PAM shadow-region decode.
// Accepted requests are registered with their stored byte; result beats leave through the
// output register, which stalls hold. A new item is taken only in ST_IDLE, after the
// read-modify-write of the byte memory and the wait for a free output register.
// Reset: synchronous; config bytes read back their defaults at once, shadow flag clears.
`timescale 1ns / 1ps
`default_nettype none

module pci_config_space_pam_decode
  import pcpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [2:0]  in_func_num,
  input  wire logic [7:0]  in_reg_addr,
  input  wire logic [7:0]  in_wdata,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_rdata,
  output logic [19:0]      out_region_base,
  output logic [16:0]      out_region_size,
  output logic             out_reads_to_dram,
  output logic             out_writes_to_dram,
  output logic             out_shadow_bios,
  output logic             out_last
);

  state_t     state_r, state_nxt;
  req_t       req_r, req_nxt;
  res_t       out_res_r, out_res_nxt;
  res_t       res1_r, res1_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       shadow_r, shadow_nxt;
  logic       rd_en;
  logic       wr_en;
  logic       out_free;
  logic [7:0] old_byte;
  dec_t       dec;

  pcpd_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (in_reg_addr),
    .rd_data (old_byte),
    .wr_en   (wr_en),
    .wr_addr (req_r.reg_addr),
    .wr_data (req_r.wdata)
  );

  pcpd_decode u_decode (
    .req      (req_r),
    .old_byte (old_byte),
    .shadow   (shadow_r),
    .dec      (dec)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      shadow_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      shadow_r    <= shadow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    out_res_r <= out_res_nxt;
    res1_r    <= res1_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_res_nxt   = out_res_r;
    res1_nxt      = res1_r;
    out_valid_nxt = out_valid_r && out_stall;
    shadow_nxt    = shadow_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          rd_en     = 1'b1;
          req_nxt   = '{op: in_op, func_num: in_func_num, reg_addr: in_reg_addr,
                        wdata: in_wdata};
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free || (dec.n == 2'd0)) begin
          wr_en      = dec.wr_en;
          shadow_nxt = dec.shadow_nxt;
          state_nxt  = ST_IDLE;
          if (dec.n != 2'd0) begin
            out_res_nxt   = dec.r0;
            out_valid_nxt = 1'b1;
          end
          if (dec.n == 2'd2) begin
            res1_nxt  = dec.r1;
            state_nxt = ST_SECOND;
          end
        end
      end
      ST_SECOND: begin
        if (out_free) begin
          out_res_nxt   = res1_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_res_r.kind;
  assign out_rdata          = out_res_r.rdata;
  assign out_region_base    = out_res_r.region_base;
  assign out_region_size    = out_res_r.region_size;
  assign out_reads_to_dram  = out_res_r.reads_to_dram;
  assign out_writes_to_dram = out_res_r.writes_to_dram;
  assign out_shadow_bios    = out_res_r.shadow_bios;
  assign out_last           = out_res_r.last;

endmodule

`default_nettype wire

>>> rtl/pcpd_checker.sv
// Port-level checker for the PAM decode block, bound to the top level.
// Depends on pcpd_pkg and pci_config_space_pam_decode_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "pci_config_space_pam_decode_defines.svh"

module pcpd_checker
  import pcpd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_kind,
  input wire logic [7:0]  out_rdata,
  input wire logic [16:0] out_region_size,
  input wire logic        out_last
);

  `PCPD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `PCPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_rdata) && $stable(out_last))
  `PCPD_ASSERT_SAME(a_read_is_last, clk, rst_n, out_valid && (out_kind == KIND_READ), out_last && (out_region_size == 17'd0))
  `PCPD_ASSERT_SAME(a_map_size, clk, rst_n, out_valid && (out_kind == KIND_MAP), (out_region_size == SIZE_16K) || (out_region_size == SIZE_64K))
  `PCPD_ASSERT_SAME(a_map_no_rdata, clk, rst_n, out_valid && (out_kind == KIND_MAP), out_rdata == 8'd0)

endmodule

bind pci_config_space_pam_decode pcpd_checker u_pcpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_rdata       (out_rdata),
  .out_region_size (out_region_size),
  .out_last        (out_last)
);

`default_nettype wire

>>> tb/pci_config_space_pam_decode_test.sv
// Self-checking testbench for the PCI host bridge configuration space with PAM decode.
// It depends on pcpd_pkg and pci_config_space_pam_decode. A scoreboard class predicts
// every result beat, and random idling and stalls exercise the valid/stall handshakes.
`timescale 1ns / 1ps

module pci_config_space_pam_decode_test;
  import pcpd_pkg::*;

  localparam int          CLK_HALF       = 10;
  localparam int          RESET_CYCLES   = 8;
  localparam int          RANDOM_ITEMS   = 1400;
  localparam int          HOLD_TRIGGER   = 300;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam logic [7:0]  ADDR_ID_LO     = 8'h00;
  localparam logic [7:0]  ADDR_ID_HI     = 8'h03;
  localparam logic [7:0]  ADDR_CLASS_LO  = 8'h08;
  localparam logic [7:0]  ADDR_CLASS_HI  = 8'h0B;
  localparam logic [7:0]  ADDR_HDR_TYPE  = 8'h0E;
  localparam logic [7:0]  ADDR_PAM1      = 8'h5A;
  localparam logic [7:0]  ADDR_TOP       = 8'hFF;
  localparam logic [2:0]  FUNC_LAST      = 3'd7;

  class config_space_tracker;
    logic [7:0] cfg_mem [256];
    logic       shadow;
    res_t       expected_beats [$];
    int         errors;
    int         accepted;

    function new();
      foreach (cfg_mem[i]) cfg_mem[i] = 8'h00;
      cfg_mem[8'h00] = 8'h86; cfg_mem[8'h01] = 8'h80;
      cfg_mem[8'h02] = 8'h30; cfg_mem[8'h03] = 8'h70;
      cfg_mem[8'h04] = 8'h06; cfg_mem[8'h07] = 8'h02;
      cfg_mem[8'h0B] = 8'h06;
      cfg_mem[8'h52] = 8'h42; cfg_mem[8'h53] = 8'h14;
      cfg_mem[8'h56] = 8'h52; cfg_mem[8'h57] = 8'h01;
      for (int a = 8'h60; a <= 8'h64; a++) cfg_mem[a] = 8'h02;
      cfg_mem[8'h67] = 8'h11; cfg_mem[8'h69] = 8'h03;
      cfg_mem[8'h70] = 8'h20; cfg_mem[8'h72] = 8'h02;
      cfg_mem[8'h74] = 8'h0E; cfg_mem[8'h78] = 8'h23;
      shadow   = 1'b0;
      errors   = 0;
      accepted = 0;
    endfunction

    function res_t region_update(logic [19:0] base, logic [16:0] size, logic [3:0] nib);
      res_t r;
      r                = '0;
      r.kind           = KIND_MAP;
      r.region_base    = base;
      r.region_size    = size;
      r.reads_to_dram  = nib[0];
      r.writes_to_dram = nib[1];
      return r;
    endfunction

    function void predict_access(req_t a);
      res_t       r;
      res_t       updates [$];
      logic [7:0] diff;
      accepted++;
      if (a.op == OP_READ) begin
        r             = '0;
        r.kind        = KIND_READ;
        r.rdata       = (a.func_num != FUNC0) ? RDATA_NONE : cfg_mem[a.reg_addr];
        r.shadow_bios = shadow;
        r.last        = 1'b1;
        expected_beats.push_back(r);
        return;
      end
      if (a.func_num != FUNC0) return;
      if (a.reg_addr inside {[ADDR_ID_LO:ADDR_ID_HI], [ADDR_CLASS_LO:ADDR_CLASS_HI],
                             ADDR_HDR_TYPE}) return;
      diff = cfg_mem[a.reg_addr] ^ a.wdata;
      case (a.reg_addr)
        ADDR_PAM0: begin
          if (diff[7:4] != 4'h0) begin
            updates.push_back(region_update(BASE_F0000, SIZE_64K, a.wdata[7:4]));
            shadow = a.wdata[4];
          end
        end
        ADDR_PAM5: begin
          if (diff[3:0] != 4'h0)
            updates.push_back(region_update(BASE_E0000, SIZE_16K, a.wdata[3:0]));
          if (diff[7:4] != 4'h0)
            updates.push_back(region_update(BASE_E4000, SIZE_16K, a.wdata[7:4]));
        end
        ADDR_PAM6: begin
          if (diff[3:0] != 4'h0)
            updates.push_back(region_update(BASE_E8000, SIZE_16K, a.wdata[3:0]));
          if (diff[7:4] != 4'h0)
            updates.push_back(region_update(BASE_EC000, SIZE_16K, a.wdata[7:4]));
        end
        default: ;
      endcase
      cfg_mem[a.reg_addr] = a.wdata;
      foreach (updates[i]) begin
        updates[i].shadow_bios = shadow;
        updates[i].last        = (i == updates.size() - 1);
        expected_beats.push_back(updates[i]);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void compare_beat(res_t got);
      res_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, actual %0h", $time, got);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("rdata", want.rdata, got.rdata);
      check_field("region_base", want.region_base, got.region_base);
      check_field("region_size", want.region_size, got.region_size);
      check_field("reads_to_dram", want.reads_to_dram, got.reads_to_dram);
      check_field("writes_to_dram", want.writes_to_dram, got.writes_to_dram);
      check_field("shadow_bios", want.shadow_bios, got.shadow_bios);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_op              = 1'b0;
  logic [2:0]  in_func_num        = 3'd0;
  logic [7:0]  in_reg_addr        = 8'h00;
  logic [7:0]  in_wdata           = 8'h00;
  logic        out_stall          = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_rdata;
  logic [19:0] out_region_base;
  logic [16:0] out_region_size;
  logic        out_reads_to_dram;
  logic        out_writes_to_dram;
  logic        out_shadow_bios;
  logic        out_last;

  config_space_tracker tracker = new();
  int                  sender_quiet = 0;
  int                  idle_cycles  = 0;

  pci_config_space_pam_decode u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_func_num        (in_func_num),
    .in_reg_addr        (in_reg_addr),
    .in_wdata           (in_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_rdata          (out_rdata),
    .out_region_base    (out_region_base),
    .out_region_size    (out_region_size),
    .out_reads_to_dram  (out_reads_to_dram),
    .out_writes_to_dram (out_writes_to_dram),
    .out_shadow_bios    (out_shadow_bios),
    .out_last           (out_last)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_access(input logic op, input logic [2:0] fn, input logic [7:0] addr,
                             input logic [7:0] data);
    int   gap;
    int   p;
    req_t a;
    gap = 0;
    if (sender_quiet > 0) begin
      sender_quiet--;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 2) sender_quiet = $urandom_range(30, 100);
      else if (p < 45) gap = idle_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_func_num <= fn;
    in_reg_addr <= addr;
    in_wdata    <= data;
    a = '{op: op, func_num: fn, reg_addr: addr, wdata: data};
    do @(posedge clk); while (in_stall);
    tracker.predict_access(a);
  endtask

  task automatic random_access();
    logic [7:0] addr;
    logic [7:0] mask;
    int         p;
    p = $urandom_range(0, 99);
    if (p < 35) begin
      case ($urandom_range(0, 2))
        0:       addr = ADDR_PAM0;
        1:       addr = ADDR_PAM5;
        default: addr = ADDR_PAM6;
      endcase
      case ($urandom_range(0, 9))
        0:       mask = 8'h00;
        1:       mask = 8'h0F;
        2:       mask = 8'hF0;
        3:       mask = 8'h0C;
        4:       mask = 8'hC0;
        5:       mask = 8'h10;
        6:       mask = 8'h03;
        7:       mask = 8'hFF;
        default: mask = 8'($urandom);
      endcase
      send_access(OP_WRITE, FUNC0, addr, tracker.cfg_mem[addr] ^ mask);
    end else if (p < 55) begin
      if ($urandom_range(0, 1)) addr = 8'($urandom);
      else addr = 8'($urandom_range(ADDR_PAM0, ADDR_PAM6));
      send_access(OP_READ, FUNC0, addr, 8'($urandom));
    end else if (p < 63) begin
      send_access(OP_READ, 3'($urandom_range(1, 7)), 8'($urandom), 8'($urandom));
    end else if (p < 78) begin
      send_access(OP_WRITE, FUNC0, 8'($urandom), 8'($urandom));
    end else if (p < 86) begin
      send_access(OP_WRITE, FUNC0, 8'($urandom_range(ADDR_ID_LO, ADDR_HDR_TYPE)),
                  8'($urandom));
    end else if (p < 92) begin
      send_access(OP_WRITE, 3'($urandom_range(1, 7)), 8'($urandom), 8'($urandom));
    end else begin
      send_access(1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin : result_side
    int   stall_left;
    int   quiet_left;
    int   p;
    bit   hold_done;
    logic stall_nxt;
    res_t got;
    stall_left = 0;
    quiet_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = {out_kind, out_rdata, out_region_base, out_region_size, out_reads_to_dram,
               out_writes_to_dram, out_shadow_bios, out_last};
        tracker.compare_beat(got);
      end
      stall_nxt = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        stall_nxt = 1'b1;
      end else if (!hold_done && tracker.accepted >= HOLD_TRIGGER) begin
        // Long hold-off so the block backs up and stalls the input side.
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        stall_nxt  = 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
      end else if (rst_n) begin
        p = $urandom_range(0, 99);
        if (p < 2) begin
          quiet_left = $urandom_range(50, 200);
        end else if (p >= 55) begin
          stall_left = idle_len() - 1;
          stall_nxt  = 1'b1;
        end
      end
      out_stall <= stall_nxt;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_access(OP_READ, FUNC0, ADDR_ID_LO, 8'h00);
    send_access(OP_READ, FUNC_LAST, ADDR_TOP, 8'hFF);
    send_access(OP_READ, FUNC0, ADDR_TOP, 8'h00);
    send_access(OP_WRITE, 3'd5, ADDR_PAM0, 8'hFF);
    send_access(OP_WRITE, FUNC0, ADDR_ID_LO, 8'h00);
    send_access(OP_WRITE, FUNC0, ADDR_HDR_TYPE, 8'hFF);
    send_access(OP_WRITE, FUNC0, ADDR_PAM0, 8'h30);
    send_access(OP_WRITE, FUNC0, ADDR_PAM0, 8'h3F);
    send_access(OP_READ, FUNC0, ADDR_PAM0, 8'h00);
    send_access(OP_WRITE, FUNC0, ADDR_PAM0, 8'h0F);
    send_access(OP_WRITE, FUNC0, ADDR_PAM5, 8'hFF);
    send_access(OP_WRITE, FUNC0, ADDR_PAM5, 8'hF3);
    send_access(OP_WRITE, FUNC0, ADDR_PAM5, 8'h73);
    send_access(OP_WRITE, FUNC0, ADDR_PAM6, 8'h0C);
    send_access(OP_WRITE, FUNC0, ADDR_PAM6, 8'hAC);
    send_access(OP_WRITE, FUNC0, ADDR_PAM6, 8'hAC);
    send_access(OP_WRITE, FUNC0, ADDR_PAM1, 8'h55);
    send_access(OP_READ, FUNC0, ADDR_PAM1, 8'h00);
    send_access(OP_WRITE, FUNC0, ADDR_TOP, 8'hFF);
    send_access(OP_READ, FUNC0, ADDR_TOP, 8'h00);
    send_access(OP_WRITE, FUNC0, ADDR_CLASS_LO, 8'h12);
    send_access(OP_READ, FUNC0, ADDR_CLASS_LO, 8'h00);
    send_access(OP_READ, 3'd1, ADDR_PAM0, 8'h00);
    send_access(OP_READ, FUNC0, ADDR_PAM6, 8'h00);

    repeat (RANDOM_ITEMS) random_access();
    in_valid <= 1'b0;

    while (tracker.expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
